// ----- sv/bspline_basis_eval_assert.svh -----
// assertion macros shared by the checker
`ifndef BSPLINE_BASIS_EVAL_ASSERT_SVH
`define BSPLINE_BASIS_EVAL_ASSERT_SVH

// antecedent implies consequent in the next cycle
`define BBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define BBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/bbe_pkg.sv -----
`default_nettype none
package bbe_pkg;
    localparam int DegreeDefault = 3;
    localparam int KnotsDefault  = 64;
    localparam int KnotW  = 32;
    localparam int BasisW = 31;
    localparam int IdxW   = 2;
    localparam int SpanW  = 6;
    localparam int KiW    = 6;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    // 64-bit dividend / 33-bit divisor, quotient kept to 64 bits
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LREAD,
        ST_RREAD,
        ST_DIFF,
        ST_DENOM,
        ST_DIVWAIT,
        ST_MUL_R,
        ST_MUL_RH,
        ST_MUL_L,
        ST_MUL_LH,
        ST_ACC,
        ST_NEXTJ,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- sv/bbe_if.sv -----
`default_nettype none
interface bbe_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  knot_index;
    logic [31:0] knot_value;
    logic [5:0]  span;
    logic [31:0] eval_point;
    modport source (output valid, operation, knot_index, knot_value, span, eval_point,
                    input ready);
    modport sink (input valid, operation, knot_index, knot_value, span, eval_point,
                  output ready);
endinterface

interface bbe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  basis_index;
    logic [30:0] basis_value;
    logic        last;
    logic        error;
    modport source (output valid, basis_index, basis_value, last, error, input ready);
    modport sink (input valid, basis_index, basis_value, last, error, output ready);
endinterface
`default_nettype wire

// ----- sv/bbe_div.sv -----
`default_nettype none
module bbe_div
    import bbe_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // restoring radix-2, one quotient bit a cycle
    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[32:0], quo_reg[63]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[32:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ----- sv/bspline_basis_eval.sv -----
// each division goes through one shared radix-2 divider; products use one 32x32 multiplier
// an evaluation runs DEGREE*(DEGREE+1)/2 divisions plus, per degree step, two knot reads,
// the differences and a table update, then DEGREE+1 output transactions
// one item at a time: a new request is taken only when idle, not while outputs are pending
// reset: asynchronous, active low, clears control state; knot table is undefined until written
`default_nettype none
module bspline_basis_eval
    import bbe_pkg::*;
#(
    parameter int DEGREE = DegreeDefault,
    parameter int KNOTS  = KnotsDefault
)
(
    input wire clk,
    input wire rst_n,
    bbe_in_if.sink    in_ch,
    bbe_out_if.source out_ch
);
    localparam int KAW = $clog2(KNOTS);
    localparam int JW  = (DEGREE > 0) ? $clog2(DEGREE + 1) : 1;

    logic [KnotW-1:0] knot_mem [KNOTS];
    logic [KnotW-1:0] rd_data_reg;
    logic [KAW-1:0]   rd_addr;

    state_t state_reg, state_next;
    logic [SpanW-1:0] span_reg;
    logic [KnotW-1:0] u_reg;
    logic [JW-1:0]    j_reg, j_next, r_reg, r_next;
    logic [KnotW-1:0] lft_reg [DEGREE+1];
    logic [KnotW-1:0] rgt_reg [DEGREE+1];
    logic [30:0]      nb_reg  [DEGREE+1];
    logic [KnotW-1:0] kl_reg;
    logic [30:0]      saved_reg;
    logic [63:0]      temp_reg, prod_reg;
    logic [30:0]      nr_part_reg;
    logic             err_reg, err_next;
    logic [IdxW-1:0]  oidx;
    logic [JW-1:0]    ocnt_reg;
    logic             ovalid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic in_fire, out_fire, span_bad;
    logic [32:0] dsum;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    bbe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign span_bad = (32'(in_ch.span) < 32'(DEGREE))
                   || (32'(in_ch.span) + 32'(DEGREE) >= 32'(KNOTS));
    assign in_ch.ready = (state_reg == ST_IDLE);

    // knot reads: left i+1-j, right i+j
    always_comb
    begin
        if (state_reg == ST_LREAD)
            rd_addr = KAW'(32'(span_reg) + 32'd1 - 32'(j_reg));
        else
            rd_addr = KAW'(32'(span_reg) + 32'(j_reg));
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && op_t'(in_ch.operation) == OP_WRITE
            && 32'(in_ch.knot_index) < 32'(KNOTS))
            knot_mem[KAW'(in_ch.knot_index)] <= in_ch.knot_value;
        rd_data_reg <= knot_mem[rd_addr];
    end

    assign dsum = {1'b0, rgt_reg[r_reg + JW'(1)]} + {1'b0, lft_reg[j_reg - r_reg]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire && op_t'(in_ch.operation) == OP_EVAL)
                    state_next = (span_bad || DEGREE == 0) ? ST_OUT : ST_LREAD;
            ST_LREAD:   state_next = ST_RREAD;
            ST_RREAD:   state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_DENOM;
            ST_DENOM:   state_next = (dsum == '0) ? ST_OUT : ST_DIVWAIT;
            ST_DIVWAIT: if (drsp.done) state_next = ST_MUL_R;
            ST_MUL_R:   state_next = ST_MUL_RH;
            ST_MUL_RH:  state_next = ST_MUL_L;
            ST_MUL_L:   state_next = ST_MUL_LH;
            ST_MUL_LH:  state_next = ST_ACC;
            ST_ACC:     state_next = (r_reg + JW'(1) == j_reg) ? ST_NEXTJ : ST_DENOM;
            ST_NEXTJ:   state_next = (32'(j_reg) == 32'(DEGREE)) ? ST_OUT : ST_LREAD;
            ST_OUT:
                if (out_fire && 32'(ocnt_reg) == 32'(DEGREE))
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        j_next        = j_reg;
        r_next        = r_reg;
        err_next      = err_reg;
        dreq.start    = 1'b0;
        dreq.dividend = {1'b0, nb_reg[r_reg], 32'd0};
        dreq.divisor  = dsum;
        case (state_reg)
            ST_IDLE:
                if (in_fire && op_t'(in_ch.operation) == OP_EVAL)
                begin
                    err_next = span_bad;
                    j_next   = JW'(1);
                    r_next   = '0;
                end
            ST_DENOM:
                if (dsum == '0)
                    err_next = 1'b1;
                else
                    dreq.start = 1'b1;
            ST_ACC:
                r_next = (r_reg + JW'(1) == j_reg) ? '0 : r_reg + JW'(1);
            ST_NEXTJ:
                j_next = j_reg + JW'(1);
            default: ;
        endcase
    end

    // one 32x32 multiplier; each term is low half of temp then high half
    assign mul_a = (state_reg == ST_MUL_R || state_reg == ST_MUL_RH)
                 ? rgt_reg[r_reg + JW'(1)] : lft_reg[j_reg - r_reg];
    assign mul_b = (state_reg == ST_MUL_RH || state_reg == ST_MUL_LH)
                 ? temp_reg[63:32] : temp_reg[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            j_reg      <= '0;
            r_reg      <= '0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            ocnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            err_reg   <= err_next;
            if (state_reg != ST_OUT && state_next == ST_OUT)
            begin
                ovalid_reg <= 1'b1;
                ocnt_reg   <= '0;
            end
            else if (out_fire)
            begin
                ocnt_reg <= ocnt_reg + JW'(1);
                if (32'(ocnt_reg) == 32'(DEGREE))
                    ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    span_reg <= in_ch.span;
                    u_reg    <= in_ch.eval_point;
                    nb_reg[0] <= 31'h4000_0000;
                    saved_reg <= '0;
                end
            ST_RREAD: kl_reg <= rd_data_reg;
            ST_DIFF:
            begin
                lft_reg[j_reg] <= (u_reg > kl_reg) ? u_reg - kl_reg : '0;
                rgt_reg[j_reg] <= (rd_data_reg > u_reg) ? rd_data_reg - u_reg : '0;
                saved_reg <= '0;
            end
            ST_DIVWAIT: if (drsp.done) temp_reg <= drsp.quotient;
            ST_MUL_R:  prod_reg <= {32'd0, mul_p[63:32]};
            ST_MUL_RH: prod_reg <= prod_reg + mul_p;
            ST_MUL_L:
            begin
                nr_part_reg <= 31'(prod_reg);
                prod_reg    <= {32'd0, mul_p[63:32]};
            end
            ST_MUL_LH: prod_reg <= prod_reg + mul_p;
            ST_ACC:
            begin
                nb_reg[r_reg] <= saved_reg + nr_part_reg;
                saved_reg     <= 31'(prod_reg);
            end
            ST_NEXTJ: nb_reg[j_reg] <= saved_reg;
            default: ;
        endcase
    end

    assign oidx               = IdxW'(ocnt_reg);
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.basis_index = oidx;
    assign out_ch.basis_value = err_reg ? '0 : nb_reg[ocnt_reg];
    assign out_ch.last        = (32'(ocnt_reg) == 32'(DEGREE));
    assign out_ch.error       = err_reg;
endmodule
`default_nettype wire

// ----- sv/bbe_checker.sv -----
`default_nettype none
`include "bspline_basis_eval_assert.svh"
module bbe_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire        out_last,
    input wire        out_error,
    input wire [30:0] out_value
);
    `BBE_ASSERT_NOW(a_no_accept_while_out, clk, rst_n, out_valid, !in_ready)
    `BBE_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_error, out_value == 31'd0)
    `BBE_ASSERT_NOW(a_value_range, clk, rst_n, out_valid, out_value <= 31'h4000_0000)
    `BBE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_last))
endmodule

bind bspline_basis_eval bbe_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.last), .out_error(out_ch.error),
    .out_value(out_ch.basis_value)
);
`default_nettype wire
